// File: src/mwd_pkg.sv
`default_nettype none

package mwd_pkg;

    // Fixed point and clamp settings of the duty path.
    localparam int DUTY_LIMIT          = 100;
    localparam int SCALE_FRACTION_BITS = 15;
    localparam int WHEELS              = 4;

    // Rounding constant for the scaled product (half an output step).
    localparam logic [23:0] ROUND_HALF = 24'(1) << (SCALE_FRACTION_BITS - 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FL_SCALES   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FR_SCALES   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RL_SCALES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RR_SCALES   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [6:0]  RAMP_STEP_RESET = 7'd2;
    localparam logic [31:0] LEFT_SCALES_RESET  = 32'h7333_8000;
    localparam logic [31:0] RIGHT_SCALES_RESET = 32'h799A_799A;

    // Wheel order in every vector: front left, front right, rear left, rear right.
    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_RL = 2;
    localparam int WHEEL_RR = 3;

    typedef enum logic [1:0] {
        OP_MOVE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_STOP  = 2'd2,
        OP_BRAKE = 2'd3
    } op_t;

    typedef logic signed [7:0] speed_t;
    typedef speed_t [WHEELS-1:0] wheel_vec_t;

    typedef struct packed {
        op_t               operation;
        logic signed [7:0] forward_speed;
        logic signed [7:0] side_speed;
        logic signed [7:0] turn_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] front_left_duty;
        logic signed [7:0] front_right_duty;
        logic signed [7:0] rear_left_duty;
        logic signed [7:0] rear_right_duty;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/mwd_kin.sv
`default_nettype none

module mwd_kin (
    input  logic signed [7:0] forward_speed,
    input  logic signed [7:0] side_speed,
    input  logic signed [7:0] turn_rate,
    output mwd_pkg::wheel_vec_t targets
);
    import mwd_pkg::*;

    // Clamp a kinematic sum to the duty range.
    function automatic speed_t clamp_duty(input logic signed [9:0] v);
        speed_t r;
        if (v > 10'sd0 + 10'(DUTY_LIMIT)) begin
            r = speed_t'(DUTY_LIMIT);
        end else if (v < -(10'sd0 + 10'(DUTY_LIMIT))) begin
            r = speed_t'(-DUTY_LIMIT);
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    logic signed [9:0] vx;
    logic signed [9:0] vy;
    logic signed [9:0] w;

    always_comb begin
        vx = {{2{forward_speed[7]}}, forward_speed};
        vy = {{2{side_speed[7]}}, side_speed};
        w  = {{2{turn_rate[7]}}, turn_rate};
        targets[WHEEL_FL] = clamp_duty(vx + vy - w);
        targets[WHEEL_FR] = clamp_duty(vx - vy + w);
        targets[WHEEL_RL] = clamp_duty(vx - vy - w);
        targets[WHEEL_RR] = clamp_duty(vx + vy + w);
    end

endmodule

`default_nettype wire

// File: src/mwd_wheel.sv
`default_nettype none

module mwd_wheel (
    input  logic signed [7:0] cur,
    input  logic signed [7:0] tgt,
    input  logic [6:0]        step,
    input  logic [31:0]       scales,
    input  logic              brake,
    output logic signed [7:0] next_cur,
    output logic signed [7:0] duty
);
    import mwd_pkg::*;

    logic signed [9:0] cur_ext;
    logic signed [9:0] tgt_ext;
    logic signed [9:0] step_ext;
    logic signed [9:0] up_sum;
    logic signed [9:0] dn_sum;
    logic signed [9:0] ramped;
    logic signed [7:0] spd;
    logic              neg;
    logic [15:0]       scale;
    logic [7:0]        mag;
    logic [23:0]       prod;
    logic [23:0]       rounded;
    logic [6:0]        duty_mag;
    logic [7:0]        duty_u;

    always_comb begin
        cur_ext  = {{2{cur[7]}}, cur};
        tgt_ext  = {{2{tgt[7]}}, tgt};
        step_ext = $signed({3'b000, step});
        up_sum   = cur_ext + step_ext;
        dn_sum   = cur_ext - step_ext;

        // Move toward the target by at most one step, stopping on it.
        if (cur_ext < tgt_ext) begin
            ramped = (up_sum > tgt_ext) ? tgt_ext : up_sum;
        end else if (cur_ext > tgt_ext) begin
            ramped = (dn_sum < tgt_ext) ? tgt_ext : dn_sum;
        end else begin
            ramped = cur_ext;
        end

        spd      = brake ? 8'sd0 : ramped[7:0];
        next_cur = spd;

        // Sign and magnitude scaling, rounded half away from zero.
        neg      = spd[7];
        scale    = neg ? scales[31:16] : scales[15:0];
        mag      = neg ? (~spd + 8'd1) : spd;
        prod     = {16'b0, mag} * {8'b0, scale};
        rounded  = (prod + ROUND_HALF) >> SCALE_FRACTION_BITS;
        duty_mag = (rounded > 24'(DUTY_LIMIT)) ? 7'(DUTY_LIMIT) : rounded[6:0];
        duty_u   = {1'b0, duty_mag};
        duty     = neg ? (~duty_u + 8'd1) : duty_u;
    end

endmodule

`default_nettype wire

// File: src/mecanum_wheel_drive_ramp_core.sv
// Mecanum drive controller with slew-limited wheel speeds.
//
// The input channel (s_valid, s_ready, s_data) carries commands: move sets
// four wheel targets from a body velocity, stop zeroes the targets, tick
// ramps each current wheel speed toward its target and returns the four
// scaled duties, and brake zeroes targets and speeds and returns zero duties.
// Move and stop return nothing; tick and brake return one transfer on the
// result channel (m_valid, m_ready, m_data).
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the ramp step and the per-wheel forward/backward scales; it is
// always ready, and writes to unknown indexes are dropped.
// Each command is captured in an input register and executed from there; a
// result is registered in the output register. One command per cycle is taken
// unless a stalled result holds it; the single-stage execute path sets this rate.
// When the receiver stalls, the result is held in the output register and
// one more command can still be captured; commands without a result keep
// flowing past a held result. Reset clears targets, speeds, the pending
// command and the output, and restores the default step and scales.
`default_nettype none

module mecanum_wheel_drive_ramp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mwd_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mwd_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mwd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);
    import mwd_pkg::*;

    // Configuration registers.
    logic [6:0]              ramp_step_reg;
    logic [WHEELS-1:0][31:0] scales_reg;

    // Input register.
    logic                    item_valid_reg;
    in_item_t                item_reg;

    // Wheel state.
    wheel_vec_t              targets_reg;
    wheel_vec_t              currents_reg;

    // Output register.
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    wheel_vec_t              move_targets;
    wheel_vec_t              next_currents;
    wheel_vec_t              duties;
    logic                    has_result;
    logic                    advance;
    logic                    brake;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg          <= RAMP_STEP_RESET;
            scales_reg[WHEEL_FL]   <= LEFT_SCALES_RESET;
            scales_reg[WHEEL_FR]   <= RIGHT_SCALES_RESET;
            scales_reg[WHEEL_RL]   <= LEFT_SCALES_RESET;
            scales_reg[WHEEL_RR]   <= RIGHT_SCALES_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RAMP_STEP: ramp_step_reg        <= cfg_data[6:0];
                REG_FL_SCALES: scales_reg[WHEEL_FL] <= cfg_data;
                REG_FR_SCALES: scales_reg[WHEEL_FR] <= cfg_data;
                REG_RL_SCALES: scales_reg[WHEEL_RL] <= cfg_data;
                REG_RR_SCALES: scales_reg[WHEEL_RR] <= cfg_data;
                default: ;
            endcase
        end
    end

    // A command with a result may only execute when the output register is
    // free or being emptied in this cycle; others always execute.
    assign brake      = (item_reg.operation == OP_BRAKE);
    assign has_result = (item_reg.operation == OP_TICK) || brake;
    assign advance    = item_valid_reg && (!has_result || !m_valid_reg || m_ready);
    assign s_ready    = !item_valid_reg || advance;

    mwd_kin u_kin (
        .forward_speed (item_reg.forward_speed),
        .side_speed    (item_reg.side_speed),
        .turn_rate     (item_reg.turn_rate),
        .targets       (move_targets)
    );

    for (genvar i = 0; i < WHEELS; i++) begin : g_wheel
        mwd_wheel u_wheel (
            .cur      (currents_reg[i]),
            .tgt      (targets_reg[i]),
            .step     (ramp_step_reg),
            .scales   (scales_reg[i]),
            .brake    (brake),
            .next_cur (next_currents[i]),
            .duty     (duties[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            item_valid_reg <= 1'b1;
        end else if (advance) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            targets_reg  <= '0;
            currents_reg <= '0;
        end else if (advance) begin
            case (item_reg.operation)
                OP_MOVE: begin
                    targets_reg <= move_targets;
                end
                OP_TICK: begin
                    currents_reg <= next_currents;
                end
                OP_STOP: begin
                    targets_reg <= '0;
                end
                OP_BRAKE: begin
                    targets_reg  <= '0;
                    currents_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            m_data_reg.front_left_duty  <= duties[WHEEL_FL];
            m_data_reg.front_right_duty <= duties[WHEEL_FR];
            m_data_reg.rear_left_duty   <= duties[WHEEL_RL];
            m_data_reg.rear_right_duty  <= duties[WHEEL_RR];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: src/mwd_checker.sv
`default_nettype none

module mwd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input mwd_pkg::out_item_t              m_data
);
    import mwd_pkg::*;

    localparam logic signed [7:0] LIM = 8'(DUTY_LIMIT);

    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Nothing comes out right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // Every duty lies within the duty limit.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.front_left_duty <= LIM) && (m_data.front_left_duty >= -LIM)
                 && (m_data.front_right_duty <= LIM) && (m_data.front_right_duty >= -LIM)
                 && (m_data.rear_left_duty <= LIM) && (m_data.rear_left_duty >= -LIM)
                 && (m_data.rear_right_duty <= LIM) && (m_data.rear_right_duty >= -LIM))
        else $error("duty out of range");

    // With the output empty, the command path never blocks.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output is empty");

endmodule

bind mecanum_wheel_drive_ramp_core mwd_checker u_mwd_checker (.*);

`default_nettype wire

// File: sim/mwd_duty_checker.sv
`timescale 1ns / 1ps

module mwd_duty_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  mwd_pkg::in_item_t               s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  mwd_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    output int                              mismatch_count,
    output int                              duties_pending,
    output int                              duties_checked
);
    import mwd_pkg::*;

    logic [6:0]  ramp_step;
    logic [31:0] wheel_scales [WHEELS];
    int          wheel_target [WHEELS];
    int          wheel_speed  [WHEELS];
    out_item_t   duty_queue [$];
    int          errors  = 0;
    int          checked = 0;

    function automatic int clamp_duty(int v);
        if (v > DUTY_LIMIT) return DUTY_LIMIT;
        if (v < -DUTY_LIMIT) return -DUTY_LIMIT;
        return v;
    endfunction

    // One slew step toward the target that never passes it.
    function automatic int ramp_speed(int cur, int tgt, int step);
        if (cur < tgt) return (cur + step > tgt) ? tgt : cur + step;
        if (cur > tgt) return (cur - step < tgt) ? tgt : cur - step;
        return cur;
    endfunction

    function automatic speed_t scaled_duty(int spd, logic [31:0] scales);
        int unsigned mag;
        int unsigned factor;
        int unsigned rounded;
        factor  = (spd < 0) ? scales[31:16] : scales[15:0];
        mag     = (spd < 0) ? -spd : spd;
        rounded = (mag * factor + (1 << (SCALE_FRACTION_BITS - 1))) >> SCALE_FRACTION_BITS;
        return speed_t'(clamp_duty((spd < 0) ? -int'(rounded) : int'(rounded)));
    endfunction

    function automatic out_item_t current_duties();
        out_item_t d;
        d.front_left_duty  = scaled_duty(wheel_speed[WHEEL_FL], wheel_scales[WHEEL_FL]);
        d.front_right_duty = scaled_duty(wheel_speed[WHEEL_FR], wheel_scales[WHEEL_FR]);
        d.rear_left_duty   = scaled_duty(wheel_speed[WHEEL_RL], wheel_scales[WHEEL_RL]);
        d.rear_right_duty  = scaled_duty(wheel_speed[WHEEL_RR], wheel_scales[WHEEL_RR]);
        return d;
    endfunction

    function automatic int field_mismatch(string field, speed_t want, speed_t got);
        if (want === got) return 0;
        $error("%s: expected %0d, actual %0d", field, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        int        vx;
        int        vy;
        int        w;
        if (!aresetn) begin
            ramp_step              = RAMP_STEP_RESET;
            wheel_scales[WHEEL_FL] = LEFT_SCALES_RESET;
            wheel_scales[WHEEL_FR] = RIGHT_SCALES_RESET;
            wheel_scales[WHEEL_RL] = LEFT_SCALES_RESET;
            wheel_scales[WHEEL_RR] = RIGHT_SCALES_RESET;
            for (int i = 0; i < WHEELS; i++) begin
                wheel_target[i] = 0;
                wheel_speed[i]  = 0;
            end
            duty_queue.delete();
        end else begin
            // A result is never the one of a command taken at the same edge,
            // so the result side is handled first.
            if (m_valid && m_ready) begin
                if (duty_queue.size() == 0) begin
                    $error("duty transfer with nothing expected: %h", m_data);
                    errors++;
                end else begin
                    want = duty_queue.pop_front();
                    errors += field_mismatch("front_left_duty", want.front_left_duty,
                                             m_data.front_left_duty);
                    errors += field_mismatch("front_right_duty", want.front_right_duty,
                                             m_data.front_right_duty);
                    errors += field_mismatch("rear_left_duty", want.rear_left_duty,
                                             m_data.rear_left_duty);
                    errors += field_mismatch("rear_right_duty", want.rear_right_duty,
                                             m_data.rear_right_duty);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RAMP_STEP: ramp_step = cfg_data[6:0];
                    REG_FL_SCALES: wheel_scales[WHEEL_FL] = cfg_data;
                    REG_FR_SCALES: wheel_scales[WHEEL_FR] = cfg_data;
                    REG_RL_SCALES: wheel_scales[WHEEL_RL] = cfg_data;
                    REG_RR_SCALES: wheel_scales[WHEEL_RR] = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                vx = int'(s_data.forward_speed);
                vy = int'(s_data.side_speed);
                w  = int'(s_data.turn_rate);
                case (s_data.operation)
                    OP_MOVE: begin
                        wheel_target[WHEEL_FL] = clamp_duty(vx + vy - w);
                        wheel_target[WHEEL_FR] = clamp_duty(vx - vy + w);
                        wheel_target[WHEEL_RL] = clamp_duty(vx - vy - w);
                        wheel_target[WHEEL_RR] = clamp_duty(vx + vy + w);
                    end
                    OP_TICK: begin
                        for (int i = 0; i < WHEELS; i++)
                            wheel_speed[i] = ramp_speed(wheel_speed[i], wheel_target[i],
                                                        int'(ramp_step));
                        duty_queue.push_back(current_duties());
                    end
                    OP_STOP: begin
                        for (int i = 0; i < WHEELS; i++) wheel_target[i] = 0;
                    end
                    OP_BRAKE: begin
                        for (int i = 0; i < WHEELS; i++) begin
                            wheel_target[i] = 0;
                            wheel_speed[i]  = 0;
                        end
                        duty_queue.push_back(current_duties());
                    end
                    default: ;
                endcase
            end
        end
        mismatch_count <= errors;
        duties_pending <= duty_queue.size();
        duties_checked <= checked;
    end

endmodule

// File: sim/tb_mecanum_wheel_drive_ramp_core.sv
`timescale 1ns / 1ps

module tb_mecanum_wheel_drive_ramp_core;
    import mwd_pkg::*;

    // The run is split into phases, each with its own register setting.
    // Phase 0 keeps the reset defaults and starts with the directed commands.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    int   mismatch_count;
    int   duties_pending;
    int   duties_checked;
    int   cycle_count   = 0;
    int   ready_hold    = 0;
    logic stall_results = 1'b0;
    logic gap_commands  = 1'b0;
    int   op_count [4];

    mecanum_wheel_drive_ramp_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker watches all three channels, predicts the duties and
    // reports how many fields went wrong.
    mwd_duty_checker duty_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .duties_pending (duties_pending),
        .duties_checked (duties_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Idle stretches mostly come from the short range and, one time in seven, from a much longer one.
    function automatic int idle_length();
        if ($urandom_range(0, 6) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t command(op_t op, int vx, int vy, int w);
        in_item_t cmd;
        cmd.operation     = op;
        cmd.forward_speed = speed_t'(vx);
        cmd.side_speed    = speed_t'(vy);
        cmd.turn_rate     = speed_t'(w);
        return cmd;
    endfunction

    // Speeds are mostly moderate so that ramps actually settle on their
    // targets; a third of them use the whole signed byte.
    function automatic speed_t random_speed();
        if ($urandom_range(0, 2) == 0) return speed_t'($urandom);
        return speed_t'(int'($urandom_range(0, 120)) - 60);
    endfunction

    // Ticks dominate so the current speeds walk all the way to the targets.
    // The speed fields are filled for every command, since the block has to
    // ignore them on tick, stop and brake.
    function automatic in_item_t random_command();
        in_item_t cmd;
        int       pick;
        pick              = $urandom_range(0, 99);
        cmd.forward_speed = random_speed();
        cmd.side_speed    = random_speed();
        cmd.turn_rate     = random_speed();
        if (pick < 20)      cmd.operation = OP_MOVE;
        else if (pick < 80) cmd.operation = OP_TICK;
        else if (pick < 92) cmd.operation = OP_STOP;
        else                cmd.operation = OP_BRAKE;
        return cmd;
    endfunction

    // Presents one command and waits for its transfer. Valid is only lowered
    // when a gap follows, so back-to-back commands keep it high.
    task automatic send_command(in_item_t cmd);
        int gap;
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        op_count[cmd.operation]++;
        gap = (gap_commands && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Waits until every expected duty set has come back. A trailing move or
    // stop has no result, so the extra wait lets it leave the input register.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (duties_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // The receiver stalls at random while stalling is enabled and is
    // otherwise always ready.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!stall_results || $urandom_range(0, 3) != 0) begin
            m_ready    <= 1'b1;
            ready_hold <= stall_results ? $urandom_range(0, 5) : 0;
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= idle_length() - 1;
        end
    end

    // A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [6:0]  step;
        logic [31:0] cfg_word;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands with the reset defaults: fully saturated
        // kinematics in both directions, ramps toward those targets, a stop
        // that leaves the speeds alone, a brake while moving, and speed
        // fields set to extremes on commands that must ignore them.
        send_command(command(OP_MOVE, 127, 127, -128));
        send_command(command(OP_TICK, -128, 127, -1));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_TICK, 127, -128, 127));
        send_command(command(OP_MOVE, -128, -128, 127));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_STOP, 127, -128, -1));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_MOVE, 50, -30, 20));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_BRAKE, -128, 127, -128));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_MOVE, 0, 0, 0));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_MOVE, -1, 1, -1));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_MOVE, 127, -128, 127));
        send_command(command(OP_TICK, 0, 0, 0));
        send_command(command(OP_BRAKE, 0, 0, 0));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                wait_until_idle();
                // Step extremes include one, the duty limit, the largest
                // 7-bit value and zero, where speeds freeze. The unused upper
                // data bits carry random values.
                case (phase)
                    1:       step = 7'd1;
                    2:       step = 7'd100;
                    3:       step = 7'd127;
                    5:       step = 7'd0;
                    6:       step = 7'd3;
                    default: step = 7'($urandom_range(1, 100));
                endcase
                cfg_word      = $urandom;
                cfg_word[6:0] = step;
                write_register(REG_RAMP_STEP, cfg_word);
                // Scale extremes: unity both ways, just under two so the
                // duty saturates, all zero, and a wheel that only drives
                // in reverse.
                for (int wheel = 0; wheel < WHEELS; wheel++) begin
                    case (phase)
                        1:       cfg_word = 32'h8000_8000;
                        2:       cfg_word = 32'hFFFF_FFFF;
                        3:       cfg_word = 32'h0000_0000;
                        5:       cfg_word = 32'hFFFF_0000;
                        default: cfg_word = $urandom;
                    endcase
                    write_register(REG_FL_SCALES + CFG_INDEX_W'(wheel), cfg_word);
                end
                // Writes past the last register must change nothing.
                if (phase == 1) begin
                    for (int idx = int'(REG_RR_SCALES) + 1; idx < 2 ** CFG_INDEX_W; idx++)
                        write_register(CFG_INDEX_W'(idx), $urandom);
                end
                cfg_valid <= 1'b0;
            end
            // Some phases run without any idling on one side.
            gap_commands  <= (phase % 3 != 1);
            stall_results <= (phase % 4 != 2);
            repeat (ITEMS_PER_PHASE) send_command(random_command());
        end

        wait_until_idle();
        $display("Sent %0d moves, %0d ticks, %0d stops and %0d brakes over %0d settings.",
                 op_count[OP_MOVE], op_count[OP_TICK], op_count[OP_STOP],
                 op_count[OP_BRAKE], PHASES);
        $display("Compared %0d duty sets field by field.", duties_checked);
        if (mismatch_count == 0 && duties_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
